// ----- rtl/mdnr_pkg.sv -----
`timescale 1ns / 1ps

package mdnr_pkg;

  localparam int DEF_MAX_DRIVERS = 16;
  localparam int SLOT_FIELD_W = 4;

  localparam logic [1:0] LV_LOW  = 2'd0;
  localparam logic [1:0] LV_HIGH = 2'd1;
  localparam logic [1:0] LV_X    = 2'd2;
  localparam logic [1:0] LV_Z    = 2'd3;

  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_SLOT = 2'd2;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_DRIVE   = 3'd2,
    ACT_FORCE   = 3'd3,
    ACT_RELEASE = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_CLEAR,
    ST_SCAN,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic exec;
    logic sweep;
    logic scan_start;
    logic scan_step;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic act_clear;
    logic sweep_last;
    logic scan_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/multi_driver_net_resolver.sv -----
`timescale 1ns / 1ps

// Resolves one net fed by up to MAX_DRIVERS driver slots, one request at a time. A request
// is taken only while the block is idle. Every request ends in a resolution scan over the
// table_fill slots ever allocated; a clear request first runs a sweep that sets every slot
// level to high-Z. The scan reads one slot per cycle through the single read port of the
// level and strength RAMs and folds it into the running strongest-driver result. The result
// sits in an output register, so the next request is taken while it waits, at the earliest
// in the cycle after the result is loaded.
module multi_driver_net_resolver import mdnr_pkg::*; #(
  parameter int MAX_DRIVERS = DEF_MAX_DRIVERS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              action,
  input  logic [3:0]              driver_slot,
  input  logic [1:0]              drive_value,
  input  logic [1:0]              drive_strength,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              net_value,
  output logic                    net_changed,
  output logic                    conflict,
  output logic [SLOT_FIELD_W-1:0] assigned_slot,
  output logic [1:0]              error_code
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  mdnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mdnr_dp #(.MAX_DRIVERS(MAX_DRIVERS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .driver_slot    (driver_slot),
    .drive_value    (drive_value),
    .drive_strength (drive_strength),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .net_value      (net_value),
    .net_changed    (net_changed),
    .conflict       (conflict),
    .assigned_slot  (assigned_slot),
    .error_code     (error_code)
  );

endmodule

// ----- rtl/mdnr_ram.sv -----
`timescale 1ns / 1ps

module mdnr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mdnr_ctrl.sv -----
`timescale 1ns / 1ps

module mdnr_ctrl import mdnr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = sts.act_clear ? ST_CLEAR : ST_SCAN;
      end
      ST_CLEAR: begin
        if (sts.sweep_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd             = '0;
    cmd.capture     = (state == ST_IDLE) && in_valid;
    cmd.rd_issue    = (state == ST_READ);
    cmd.exec        = (state == ST_EXEC);
    cmd.sweep       = (state == ST_CLEAR);
    cmd.scan_start  = ((state == ST_EXEC) && !sts.act_clear) ||
                      ((state == ST_CLEAR) && sts.sweep_last);
    cmd.scan_step   = (state == ST_SCAN);
    cmd.result_load = (state == ST_RESULT) && sts.out_free;
  end

endmodule

// ----- rtl/mdnr_dp.sv -----
`timescale 1ns / 1ps

module mdnr_dp import mdnr_pkg::*; #(
  parameter int MAX_DRIVERS = DEF_MAX_DRIVERS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [2:0]              action,
  input  logic [3:0]              driver_slot,
  input  logic [1:0]              drive_value,
  input  logic [1:0]              drive_strength,
  input  ctrl_cmd_t               cmd,
  output ctrl_sts_t               sts,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              net_value,
  output logic                    net_changed,
  output logic                    conflict,
  output logic [SLOT_FIELD_W-1:0] assigned_slot,
  output logic [1:0]              error_code
);

  localparam int SLOT_W = $clog2(MAX_DRIVERS);
  localparam int CNT_W  = $clog2(MAX_DRIVERS + 1);
  localparam int CMP_W  = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_DRIVERS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_DRIVERS - 1);

  // Captured request.
  action_t                 act_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  logic [1:0]              val_q;
  logic [1:0]              str_q;

  // Net and driver table state.
  logic [MAX_DRIVERS-1:0] slot_valid;
  logic [CNT_W-1:0]       free_count;
  logic [CNT_W-1:0]       table_fill;
  logic                   force_active;
  logic [1:0]             forced_level;
  logic [1:0]             net_level;

  // Scan state.
  logic [CNT_W-1:0] idx;
  logic             pend;
  logic             pend_valid;
  logic             any_q;
  logic [1:0]       best_q;
  logic [1:0]       lvl_q;
  logic             lo_q;
  logic             hi_q;

  logic                    resolve_q;
  logic                    changed_q;
  logic [SLOT_FIELD_W-1:0] assigned_q;
  logic [1:0]              err_q;
  logic                    resolve_next;
  logic                    changed_next;
  logic [SLOT_FIELD_W-1:0] assigned_next;
  logic [1:0]              err_next;

  // RAM ports.
  logic              lvl_we;
  logic [SLOT_W-1:0] lvl_waddr;
  logic [1:0]        lvl_wdata;
  logic [SLOT_W-1:0] lvl_raddr;
  logic [1:0]        lvl_rdata;
  logic              str_we;
  logic [SLOT_W-1:0] str_waddr;
  logic [1:0]        str_wdata;
  logic [1:0]        str_rdata;
  logic              fs_we;
  logic [SLOT_W-1:0] fs_waddr;
  logic [SLOT_W-1:0] fs_wdata;
  logic [SLOT_W-1:0] fs_raddr;
  logic [SLOT_W-1:0] fs_rdata;

  logic [SLOT_W-1:0] slot_ix;
  logic [SLOT_W-1:0] idx_ix;
  logic [CNT_W-1:0]  fc_dec;
  logic              slot_ok;
  logic              add_ok;
  logic [SLOT_W-1:0] add_s;
  logic              rem_ok;
  logic              drv_diff;
  logic              scan_issue;
  logic [1:0]        res_lvl;
  logic              res_changed;

  assign slot_ix    = SLOT_W'(slot_q);
  assign idx_ix     = idx[SLOT_W-1:0];
  assign fc_dec     = free_count - CNT_W'(1);
  assign slot_ok    = (CMP_W'(slot_q) < CMP_W'(table_fill)) && slot_valid[slot_ix];
  assign rem_ok     = slot_ok && (free_count < MAX_CNT);
  assign drv_diff   = (lvl_rdata != val_q);
  assign scan_issue = cmd.scan_step && (idx < table_fill);

  // A freed slot is popped first; otherwise the table grows by one.
  always_comb begin
    add_ok = 1'b1;
    add_s  = table_fill[SLOT_W-1:0];
    if (free_count != '0) begin
      add_s = fs_rdata;
    end else if (table_fill >= MAX_CNT) begin
      add_ok = 1'b0;
    end
  end

  assign lvl_raddr = cmd.rd_issue ? slot_ix : idx_ix;
  assign fs_raddr  = fc_dec[SLOT_W-1:0];

  always_comb begin
    lvl_we    = 1'b0;
    lvl_waddr = idx_ix;
    lvl_wdata = LV_Z;
    str_we    = 1'b0;
    str_waddr = slot_ix;
    str_wdata = str_q;
    fs_we     = 1'b0;
    fs_waddr  = free_count[SLOT_W-1:0];
    fs_wdata  = slot_ix;
    if (cmd.sweep) begin
      lvl_we = 1'b1;
    end else if (cmd.exec) begin
      case (act_q)
        ACT_ADD: begin
          lvl_we    = add_ok;
          lvl_waddr = add_s;
          lvl_wdata = val_q;
          str_we    = add_ok;
          str_waddr = add_s;
        end
        ACT_REMOVE: begin
          lvl_we    = rem_ok;
          lvl_waddr = slot_ix;
          str_we    = rem_ok;
          str_wdata = 2'd0;
          fs_we     = rem_ok;
        end
        ACT_DRIVE: begin
          lvl_we    = slot_ok && drv_diff;
          lvl_waddr = slot_ix;
          lvl_wdata = val_q;
        end
        default: begin
        end
      endcase
    end
  end

  mdnr_ram #(.WIDTH(2), .DEPTH(MAX_DRIVERS)) u_level_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (lvl_waddr),
    .wdata (lvl_wdata),
    .raddr (lvl_raddr),
    .rdata (lvl_rdata)
  );

  mdnr_ram #(.WIDTH(2), .DEPTH(MAX_DRIVERS)) u_strength_ram (
    .clk   (clk),
    .we    (str_we),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .raddr (idx_ix),
    .rdata (str_rdata)
  );

  mdnr_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_DRIVERS)) u_free_stack (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  always_comb begin
    resolve_next  = 1'b0;
    changed_next  = 1'b0;
    err_next      = ERR_OK;
    assigned_next = '0;
    case (act_q)
      ACT_ADD: begin
        if (add_ok) begin
          assigned_next = SLOT_FIELD_W'(add_s);
        end else begin
          err_next = ERR_FULL;
        end
      end
      ACT_REMOVE: begin
        if (!rem_ok) begin
          err_next = ERR_SLOT;
        end
      end
      ACT_DRIVE: begin
        if (!slot_ok) begin
          err_next = ERR_SLOT;
        end else if (drv_diff) begin
          resolve_next = 1'b1;
        end
      end
      ACT_FORCE:   resolve_next = 1'b1;
      ACT_RELEASE: resolve_next = force_active;
      ACT_CLEAR:   changed_next = (net_level != LV_Z);
      default: begin
      end
    endcase
  end

  always_comb begin
    res_lvl     = net_level;
    res_changed = changed_q;
    if (resolve_q) begin
      res_lvl     = force_active ? forced_level : lvl_q;
      res_changed = (res_lvl != net_level);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      free_count   <= '0;
      table_fill   <= '0;
      force_active <= 1'b0;
      forced_level <= LV_Z;
      net_level    <= LV_Z;
      idx          <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (act_q)
          ACT_ADD: begin
            if (add_ok) begin
              slot_valid[add_s] <= 1'b1;
              if (free_count != '0) begin
                free_count <= fc_dec;
              end else begin
                table_fill <= table_fill + CNT_W'(1);
              end
            end
          end
          ACT_REMOVE: begin
            if (rem_ok) begin
              slot_valid[slot_ix] <= 1'b0;
              free_count          <= free_count + CNT_W'(1);
            end
          end
          ACT_FORCE: begin
            force_active <= 1'b1;
            forced_level <= val_q;
          end
          ACT_RELEASE: force_active <= 1'b0;
          ACT_CLEAR: begin
            force_active <= 1'b0;
            net_level    <= LV_Z;
          end
          default: begin
          end
        endcase
      end
      // The index walks the sweep and the scan, and restarts at each phase.
      if (cmd.exec || cmd.scan_start) begin
        idx <= '0;
      end else if (cmd.sweep || scan_issue) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.scan_start) begin
        pend <= 1'b0;
      end else if (cmd.scan_step) begin
        pend <= scan_issue;
      end
      if (cmd.result_load) begin
        net_level <= res_lvl;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action_t'(action);
      slot_q <= driver_slot;
      val_q  <= drive_value;
      str_q  <= drive_strength;
    end
    if (cmd.exec) begin
      resolve_q  <= resolve_next;
      changed_q  <= changed_next;
      err_q      <= err_next;
      assigned_q <= assigned_next;
    end
    if (cmd.scan_start) begin
      any_q  <= 1'b0;
      best_q <= 2'd0;
      lvl_q  <= LV_Z;
      lo_q   <= 1'b0;
      hi_q   <= 1'b0;
    end else if (cmd.scan_step) begin
      pend_valid <= slot_valid[idx_ix];
      // The read issued last cycle is folded in now.
      if (pend && pend_valid && (lvl_rdata != LV_Z)) begin
        if (!any_q || (str_rdata > best_q)) begin
          any_q  <= 1'b1;
          best_q <= str_rdata;
          lvl_q  <= lvl_rdata;
          lo_q   <= (lvl_rdata == LV_LOW);
          hi_q   <= (lvl_rdata == LV_HIGH);
        end else if (str_rdata == best_q) begin
          if (lvl_rdata != lvl_q) begin
            lvl_q <= LV_X;
          end
          if (lvl_rdata == LV_LOW) begin
            lo_q <= 1'b1;
          end
          if (lvl_rdata == LV_HIGH) begin
            hi_q <= 1'b1;
          end
        end
      end
    end
    if (cmd.result_load) begin
      net_value     <= res_lvl;
      net_changed   <= res_changed;
      conflict      <= lo_q && hi_q;
      assigned_slot <= assigned_q;
      error_code    <= err_q;
    end
  end

  always_comb begin
    sts.act_clear  = (act_q == ACT_CLEAR);
    sts.sweep_last = (idx_ix == LAST_SLOT);
    sts.scan_done  = !pend && (idx == table_fill);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ----- sim/multi_driver_net_resolver_tb.sv -----
`timescale 1ns / 1ps

module multi_driver_net_resolver_tb import mdnr_pkg::*;;

  localparam int MAX_DRIVERS = DEF_MAX_DRIVERS;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * MAX_DRIVERS + 40;
  localparam int REPORT_LIMIT = 10;

  // Action codes the block must accept and ignore.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [1:0] net_value;
    logic       net_changed;
    logic       conflict;
    logic [3:0] assigned_slot;
    logic [1:0] error_code;
  } net_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] action = '0;
  logic [3:0] driver_slot = '0;
  logic [1:0] drive_value = '0;
  logic [1:0] drive_strength = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] net_value;
  logic       net_changed;
  logic       conflict;
  logic [SLOT_FIELD_W-1:0] assigned_slot;
  logic [1:0] error_code;

  // Shadow copy of the driver table and the net.
  logic       drv_valid [MAX_DRIVERS];
  logic [1:0] drv_level [MAX_DRIVERS];
  logic [1:0] drv_strength [MAX_DRIVERS];
  logic [3:0] freed_slots [MAX_DRIVERS];
  int         freed_count = 0;
  int         fill_count = 0;
  logic       force_on = 1'b0;
  logic [1:0] force_level = LV_Z;
  logic [1:0] net_now = LV_Z;

  net_result_t expected_results[$];
  net_result_t seen_result;
  net_result_t due_result;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  multi_driver_net_resolver u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .driver_slot    (driver_slot),
    .drive_value    (drive_value),
    .drive_strength (drive_strength),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .net_value      (net_value),
    .net_changed    (net_changed),
    .conflict       (conflict),
    .assigned_slot  (assigned_slot),
    .error_code     (error_code)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Level of the strongest non-high-Z drivers; a tie between different levels is unknown.
  function automatic logic [1:0] table_level();
    logic [1:0] lvl;
    logic [1:0] best;
    bit         any;
    lvl = LV_Z;
    best = '0;
    any = 1'b0;
    for (int i = 0; i < fill_count; i++) begin
      if (drv_valid[i] && drv_level[i] != LV_Z) begin
        if (!any || drv_strength[i] > best) begin
          any = 1'b1;
          best = drv_strength[i];
          lvl = drv_level[i];
        end else if (drv_strength[i] == best && drv_level[i] != lvl) begin
          lvl = LV_X;
        end
      end
    end
    return lvl;
  endfunction

  function automatic logic table_conflict();
    logic [1:0] best;
    bit         any;
    bit         lo;
    bit         hi;
    best = '0;
    any = 1'b0;
    lo = 1'b0;
    hi = 1'b0;
    for (int i = 0; i < fill_count; i++) begin
      if (drv_valid[i] && drv_level[i] != LV_Z) begin
        if (!any || drv_strength[i] > best) begin
          any = 1'b1;
          best = drv_strength[i];
          lo = 1'b0;
          hi = 1'b0;
        end
        if (drv_strength[i] == best) begin
          if (drv_level[i] == LV_LOW) lo = 1'b1;
          if (drv_level[i] == LV_HIGH) hi = 1'b1;
        end
      end
    end
    return lo && hi;
  endfunction

  function automatic logic resolve_net();
    logic [1:0] lvl;
    lvl = force_on ? force_level : table_level();
    if (lvl == net_now) return 1'b0;
    net_now = lvl;
    return 1'b1;
  endfunction

  function automatic bit slot_registered(logic [3:0] slot);
    return int'(slot) < fill_count && drv_valid[slot];
  endfunction

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic net_result_t apply_request(logic [2:0] act, logic [3:0] slot,
                                                logic [1:0] val, logic [1:0] str);
    net_result_t r;
    r = '0;
    case (act)
      ACT_ADD: begin
        if (freed_count > 0) begin
          freed_count--;
          r.assigned_slot = freed_slots[freed_count];
        end else if (fill_count < MAX_DRIVERS) begin
          r.assigned_slot = fill_count[3:0];
          fill_count++;
        end else begin
          r.error_code = ERR_FULL;
        end
        if (r.error_code == ERR_OK) begin
          drv_valid[r.assigned_slot] = 1'b1;
          drv_level[r.assigned_slot] = val;
          drv_strength[r.assigned_slot] = str;
        end
      end
      ACT_REMOVE: begin
        if (!slot_registered(slot) || freed_count >= MAX_DRIVERS) begin
          r.error_code = ERR_SLOT;
        end else begin
          drv_valid[slot] = 1'b0;
          drv_level[slot] = LV_Z;
          drv_strength[slot] = '0;
          freed_slots[freed_count] = slot;
          freed_count++;
        end
      end
      ACT_DRIVE: begin
        if (!slot_registered(slot)) begin
          r.error_code = ERR_SLOT;
        end else if (drv_level[slot] != val) begin
          drv_level[slot] = val;
          r.net_changed = resolve_net();
        end
      end
      ACT_FORCE: begin
        force_on = 1'b1;
        force_level = val;
        r.net_changed = resolve_net();
      end
      ACT_RELEASE: begin
        if (force_on) begin
          force_on = 1'b0;
          r.net_changed = resolve_net();
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < MAX_DRIVERS; i++) drv_level[i] = LV_Z;
        force_on = 1'b0;
        r.net_changed = (net_now != LV_Z);
        net_now = LV_Z;
      end
      default: begin
      end
    endcase
    r.net_value = net_now;
    r.conflict = table_conflict();
    return r;
  endfunction

  task automatic send_request(logic [2:0] act, logic [3:0] slot, logic [1:0] val,
                              logic [1:0] str);
    if (!tx_steady && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    driver_slot <= slot;
    drive_value <= val;
    drive_strength <= str;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.insert(expected_results.size(), apply_request(act, slot, val, str));
  endtask

  // Mostly well-formed traffic: slots are usually ones already handed out.
  task automatic send_random_request(int add_pct);
    logic [2:0] act;
    logic [3:0] slot;
    int         pick;
    pick = int'($urandom_range(99));
    if (pick < add_pct) begin
      act = ACT_ADD;
    end else begin
      pick = int'($urandom_range(99));
      if (pick < 25) act = ACT_REMOVE;
      else if (pick < 70) act = ACT_DRIVE;
      else if (pick < 80) act = ACT_FORCE;
      else if (pick < 90) act = ACT_RELEASE;
      else if (pick < 96) act = ACT_CLEAR;
      else if (pick < 98) act = ACT_SPARE6;
      else act = ACT_SPARE7;
    end
    if (fill_count > 0 && $urandom_range(99) < 85) slot = 4'($urandom_range(fill_count - 1));
    else slot = 4'($urandom_range(15));
    send_request(act, slot, 2'($urandom_range(3)), 2'($urandom_range(3)));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_directed();
    send_request(ACT_RELEASE, 4'd0, LV_LOW, 2'd0);
    send_request(ACT_DRIVE, 4'd0, LV_HIGH, 2'd0);
    send_request(ACT_REMOVE, 4'd15, LV_LOW, 2'd0);
    send_request(ACT_ADD, 4'd0, LV_LOW, 2'd3);
    send_request(ACT_ADD, 4'd0, LV_HIGH, 2'd3);
    send_request(ACT_ADD, 4'd0, LV_Z, 2'd0);
    send_request(ACT_DRIVE, 4'd0, LV_LOW, 2'd0);
    // Equal strongest drivers at opposite levels: unknown and a conflict.
    send_request(ACT_DRIVE, 4'd2, LV_HIGH, 2'd0);
    send_request(ACT_DRIVE, 4'd1, LV_Z, 2'd0);
    send_request(ACT_FORCE, 4'd0, LV_HIGH, 2'd0);
    send_request(ACT_DRIVE, 4'd1, LV_X, 2'd3);
    send_request(ACT_RELEASE, 4'd0, LV_LOW, 2'd0);
    send_request(ACT_FORCE, 4'd15, LV_Z, 2'd3);
    send_request(ACT_REMOVE, 4'd1, LV_LOW, 2'd0);
    send_request(ACT_REMOVE, 4'd0, LV_LOW, 2'd0);
    send_request(ACT_REMOVE, 4'd0, LV_LOW, 2'd0);
    // Freed slots come back last-freed first before the table grows.
    send_request(ACT_ADD, 4'd0, LV_HIGH, 2'd1);
    send_request(ACT_ADD, 4'd0, LV_X, 2'd2);
    send_request(ACT_ADD, 4'd0, LV_LOW, 2'd3);
    send_request(ACT_CLEAR, 4'd0, LV_LOW, 2'd0);
    send_request(ACT_SPARE6, 4'd15, LV_Z, 2'd3);
    send_request(ACT_SPARE7, 4'd3, LV_HIGH, 2'd1);
    send_request(ACT_DRIVE, 4'd15, LV_HIGH, 2'd3);
  endtask

  task automatic test_random_mix();
    repeat (200) send_random_request(15);
  endtask

  // Add-heavy traffic runs the table up to its limit and past it.
  task automatic test_table_full();
    repeat (80) send_random_request(55);
  endtask

  task automatic test_backpressure();
    hold_requests++;
    tx_steady = 1'b1;
    repeat (24) send_random_request(20);
    tx_steady = 1'b0;
  endtask

  task automatic test_paused_stream();
    wait_for_results();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (60) send_random_request(20);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (20) send_random_request(20);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen_result = '{net_value, net_changed, conflict, assigned_slot, error_code};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result %p at %0t", seen_result, $realtime);
        end else begin
          due_result = expected_results.pop_front();
          if (seen_result !== due_result) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result mismatch at %0t: expected %p, got %p", $realtime,
                       due_result, seen_result);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rx_steady || ($urandom_range(99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_DRIVERS; i++) begin
      drv_valid[i] = 1'b0;
      drv_level[i] = LV_Z;
      drv_strength[i] = '0;
      freed_slots[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_table_full();
    test_backpressure();
    test_paused_stream();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mdnr_pkg.sv
rtl/mdnr_ram.sv
rtl/mdnr_ctrl.sv
rtl/mdnr_dp.sv
rtl/multi_driver_net_resolver.sv
sim/multi_driver_net_resolver_tb.sv
